@@ hw/rtl/tbea_pkg.sv @@
package tbea_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int EVENT_ID_BITS = 16;
  localparam int QIDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int MODE_W  = 3;
  localparam int COST_W  = 20;
  localparam int CRED_W  = 30;
  localparam int ELAP_W  = 32;
  localparam int ALU_W   = 33;
  localparam int MS_W    = 16;
  // deficit below 2^20 us, so the rounded-up ms value fits in 11 bits
  localparam int QUO_W   = 11;
  // divide by 1000 as a multiply by 2^30/1000 rounded up, exact for dividends below 2^21
  localparam int RND_W       = 21;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_MS    = 1073742;
  localparam int PROD_W      = RECIP_SHIFT + QUO_W;
  localparam int TDATA_IN_W  = 48;
  localparam int TDATA_OUT_W = 72;

  localparam logic [COST_W-1:0] COST_RESET = COST_W'(1000000);
  localparam logic [CRED_W-1:0] CAP_RESET  = CRED_W'(1000000);
  localparam int US_PER_MS   = 1000;
  localparam int ROUND_UP    = 999;
  localparam int MIN_WAIT_MS = 4;

  localparam logic KIND_ADMIT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic CFG_UNIT_COST = 1'b0;
  localparam logic CFG_CREDIT_CAP = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUBMIT  = 3'd0,
    MODE_TICK    = 3'd1,
    MODE_CANCEL  = 3'd2,
    MODE_PAUSE   = 3'd3,
    MODE_UNPAUSE = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_ADMIT  = 2'd0,
    ST_QUEUED = 2'd1,
    ST_REJECT = 2'd2,
    ST_DONE   = 2'd3
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SAT,
    S_CLAMP,
    S_SUB_ISSUE,
    S_SUB_CHK,
    S_DRN_RD,
    S_DRN_POP,
    S_ARM_ISSUE,
    S_ARM_CHK,
    S_RND,
    S_MS,
    S_CAN_RD,
    S_CAN_CMP,
    S_STATUS
  } seq_state_t;

  typedef struct packed {
    logic              valid;
    alu_op_t           op;
    logic [ALU_W-1:0]  a;
    logic [ALU_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic                     push;
    logic [EVENT_ID_BITS-1:0] push_id;
    logic                     pop;
    logic                     rd_en;
    logic [QIDX_W-1:0]        rd_addr;
    logic                     kill;
    logic [QIDX_W-1:0]        kill_addr;
  } queue_ctl_t;

  typedef struct packed {
    logic                     pad;
    logic [CRED_W-1:0]        credit_us;
    logic [QCNT_W-1:0]        queued_count;
    logic                     timer_cancel;
    logic [MS_W-1:0]          wait_ms;
    logic                     arm_timer;
    status_t                  status;
    logic [EVENT_ID_BITS-1:0] admitted_id;
  } res_data_t;

  // ring index of base + offset, offset never above the depth
  function automatic logic [QIDX_W-1:0] qwrap(input logic [QCNT_W:0] sum);
    logic [QCNT_W:0] s;
    s = (sum >= (QCNT_W+1)'(QUEUE_DEPTH)) ? sum - (QCNT_W+1)'(QUEUE_DEPTH) : sum;
    return s[QIDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/tbea_alu.sv @@
module tbea_alu (
  input  logic                       clk,
  input  tbea_pkg::alu_req_t         req,
  output logic [tbea_pkg::ALU_W-1:0] res,
  output logic                       neg
);
  import tbea_pkg::*;

  logic [ALU_W:0] sum;

  always_comb begin
    case (req.op)
      ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
      default: sum = '0;
    endcase
  end

  // result held until the next request
  always_ff @(posedge clk) begin
    if (req.valid) begin
      res <= sum[ALU_W-1:0];
      neg <= sum[ALU_W];
    end
  end

endmodule

@@ hw/rtl/tbea_queue.sv @@
module tbea_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  tbea_pkg::queue_ctl_t               ctl,
  output logic [tbea_pkg::QIDX_W-1:0]        head,
  output logic [tbea_pkg::QCNT_W-1:0]        count,
  output logic [tbea_pkg::EVENT_ID_BITS-1:0] rd_data,
  output logic [tbea_pkg::QUEUE_DEPTH-1:0]   live
);
  import tbea_pkg::*;

  logic [EVENT_ID_BITS-1:0] ids [QUEUE_DEPTH];
  logic [QIDX_W-1:0]        tail;
  logic [QIDX_W-1:0]        head_inc;

  assign tail     = qwrap((QCNT_W+1)'(head) + (QCNT_W+1)'(count));
  assign head_inc = qwrap((QCNT_W+1)'(head) + (QCNT_W+1)'(1));

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ids[tail] <= ctl.push_id;
    end
    if (ctl.rd_en) begin
      rd_data <= ids[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      live  <= '0;
    end else begin
      if (ctl.push) begin
        live[tail] <= 1'b1;
        count      <= count + QCNT_W'(1);
      end
      if (ctl.pop) begin
        live[head] <= 1'b0;
        head       <= head_inc;
        count      <= count - QCNT_W'(1);
      end
      if (ctl.kill) begin
        live[ctl.kill_addr] <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> (count < QCNT_W'(QUEUE_DEPTH)) && !ctl.pop)
    else $error("push into full queue or together with pop");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

@@ hw/rtl/token_bucket_event_admitter_core.sv @@
// sequence: a submit runs dispatch, saturating add, clamp, cost subtract and check, then status;
//   a wake timer adds arm, round and ms steps; drain and cancel read then pop or compare per entry
// throughput: one input word at a time, ready only when the sequencer is idle and no config write is pending;
//   the shared 33-bit add/subtract unit and the single queue read port set the cycle count
// reset: sync, active high; cost and cap return to 1000000 us, credit to the cap, queue empty,
//   not paused, no timer armed; queued ids are not cleared
module token_bucket_event_admitter_core (
  input  logic                             clk,
  input  logic                             rst,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [tbea_pkg::CRED_W-1:0]      cfg_data,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tbea_pkg::TDATA_IN_W-1:0]  s_tdata,  // event_id[15:0], elapsed_us[47:16]
  input  logic [tbea_pkg::MODE_W-1:0]      s_tuser,  // mode[2:0]
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tbea_pkg::TDATA_OUT_W-1:0] m_tdata,  // admitted_id, status, arm_timer, wait_ms,
                                                      // timer_cancel, queued_count, credit_us, pad
  output logic                             m_tuser,  // kind
  output logic                             m_tlast   // last
);
  import tbea_pkg::*;

  seq_state_t state, state_next;

  mode_t                    mode_r, mode_next;
  logic [EVENT_ID_BITS-1:0] id_r, id_next;
  logic [ELAP_W-1:0]        elapsed_r, elapsed_next;
  logic [COST_W-1:0]        cost, cost_next;
  logic [CRED_W-1:0]        cap, cap_next;
  logic [CRED_W-1:0]        credit, credit_next;
  logic                     paused, paused_next;
  logic                     timer_armed, timer_armed_next;
  logic [ALU_W-1:0]         acc, acc_next;
  logic [QUO_W-1:0]         quo, quo_next;
  logic [QCNT_W-1:0]        idx, idx_next;
  logic [QIDX_W-1:0]        can_addr, can_addr_next;
  status_t                  status_r, status_next;
  logic [MS_W-1:0]          wait_r, wait_next;
  logic                     tcancel, tcancel_next;

  alu_req_t                 alu_req;
  logic [ALU_W-1:0]         alu_res;
  logic                     alu_neg;
  queue_ctl_t               qctl;
  logic [QIDX_W-1:0]        q_head;
  logic [QCNT_W-1:0]        q_count;
  logic [EVENT_ID_BITS-1:0] q_rd_data;
  logic [QUEUE_DEPTH-1:0]   q_live;

  logic                     out_free;
  logic                     out_load;
  res_data_t                out_word;
  logic                     out_kind;
  logic                     out_last;
  logic [PROD_W-1:0]        ms_prod;
  logic [QIDX_W-1:0]        scan_addr;

  tbea_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .res (alu_res),
    .neg (alu_neg)
  );

  tbea_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (qctl),
    .head    (q_head),
    .count   (q_count),
    .rd_data (q_rd_data),
    .live    (q_live)
  );

  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = (state == S_IDLE);
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign ms_prod   = PROD_W'(alu_res[RND_W-1:0]) * PROD_W'(RECIP_MS);
  assign scan_addr = qwrap((QCNT_W+1)'(q_head) + (QCNT_W+1)'(idx));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (mode_r)
          MODE_SUBMIT, MODE_TICK: state_next = S_SAT;
          MODE_CANCEL:            state_next = S_CAN_RD;
          MODE_UNPAUSE:           state_next = paused ? S_DRN_RD : S_STATUS;
          default:                state_next = S_STATUS;
        endcase
      end
      S_SAT: state_next = S_CLAMP;
      S_CLAMP: begin
        if (mode_r == MODE_SUBMIT) state_next = S_SUB_ISSUE;
        else                       state_next = paused ? S_ARM_ISSUE : S_DRN_RD;
      end
      S_SUB_ISSUE: state_next = S_SUB_CHK;
      S_SUB_CHK: begin
        if (!paused && !alu_neg) begin
          if (out_free) state_next = S_STATUS;
        end else if (q_count < QCNT_W'(QUEUE_DEPTH)) begin
          state_next = S_ARM_ISSUE;
        end else begin
          state_next = S_STATUS;
        end
      end
      S_DRN_RD: state_next = (q_count == '0) ? S_ARM_ISSUE : S_DRN_POP;
      S_DRN_POP: begin
        if (alu_neg)                       state_next = S_ARM_ISSUE;
        else if (!q_live[q_head] || out_free) state_next = S_DRN_RD;
      end
      S_ARM_ISSUE: begin
        if (timer_armed || paused || q_count == '0) state_next = S_STATUS;
        else                                        state_next = S_ARM_CHK;
      end
      S_ARM_CHK: state_next = (alu_neg || alu_res == '0) ? S_STATUS : S_RND;
      S_RND:     state_next = S_MS;
      S_MS:      state_next = S_STATUS;
      S_CAN_RD:  state_next = (idx == q_count) ? S_STATUS : S_CAN_CMP;
      S_CAN_CMP: state_next = S_CAN_RD;
      S_STATUS: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    mode_next        = mode_r;
    id_next          = id_r;
    elapsed_next     = elapsed_r;
    cost_next        = cost;
    cap_next         = cap;
    credit_next      = credit;
    paused_next      = paused;
    timer_armed_next = timer_armed;
    acc_next         = acc;
    quo_next         = quo;
    idx_next         = idx;
    can_addr_next    = can_addr;
    status_next      = status_r;
    wait_next        = wait_r;
    tcancel_next     = tcancel;
    alu_req          = '0;
    qctl             = '0;
    out_load         = 1'b0;
    out_kind         = KIND_ADMIT;
    out_last         = 1'b0;
    out_word         = '0;
    out_word.queued_count = q_count;
    out_word.credit_us    = credit;

    case (state)
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          case (cfg_index)
            CFG_UNIT_COST: cost_next = cfg_data[COST_W-1:0];
            CFG_CREDIT_CAP: begin
              cap_next    = cfg_data;
              credit_next = cfg_data;
            end
            default: ;
          endcase
        end
        if (s_tvalid && s_tready) begin
          mode_next    = mode_t'(s_tuser);
          id_next      = s_tdata[EVENT_ID_BITS-1:0];
          elapsed_next = s_tdata[EVENT_ID_BITS +: ELAP_W];
          status_next  = ST_DONE;
          wait_next    = '0;
          tcancel_next = 1'b0;
        end
      end
      S_DISPATCH: begin
        case (mode_r)
          MODE_SUBMIT, MODE_TICK: begin
            if (mode_r == MODE_TICK) timer_armed_next = 1'b0;
            alu_req = '{valid: 1'b1, op: ALU_ADD, a: ALU_W'(credit), b: ALU_W'(elapsed_r)};
          end
          MODE_CANCEL: idx_next = '0;
          MODE_PAUSE: begin
            if (!paused) begin
              paused_next = 1'b1;
              if (timer_armed) begin
                timer_armed_next = 1'b0;
                tcancel_next     = 1'b1;
              end
            end
          end
          MODE_UNPAUSE: paused_next = 1'b0;
          MODE_CLEAR:   credit_next = '0;
          default: ;
        endcase
      end
      S_SAT: begin
        acc_next = alu_res;
        alu_req  = '{valid: 1'b1, op: ALU_SUB, a: ALU_W'(cap), b: alu_res};
      end
      S_CLAMP: credit_next = alu_neg ? cap : acc[CRED_W-1:0];
      S_SUB_ISSUE: begin
        alu_req = '{valid: 1'b1, op: ALU_SUB, a: ALU_W'(credit), b: ALU_W'(cost)};
      end
      S_SUB_CHK: begin
        if (!paused && !alu_neg) begin
          if (out_free) begin
            credit_next          = alu_res[CRED_W-1:0];
            status_next          = ST_ADMIT;
            out_load             = 1'b1;
            out_word.admitted_id = id_r;
            out_word.credit_us   = alu_res[CRED_W-1:0];
          end
        end else if (q_count < QCNT_W'(QUEUE_DEPTH)) begin
          qctl.push    = 1'b1;
          qctl.push_id = id_r;
          status_next  = ST_QUEUED;
        end else begin
          status_next = ST_REJECT;
        end
      end
      S_DRN_RD: begin
        if (q_count != '0) begin
          alu_req      = '{valid: 1'b1, op: ALU_SUB, a: ALU_W'(credit), b: ALU_W'(cost)};
          qctl.rd_en   = 1'b1;
          qctl.rd_addr = q_head;
        end
      end
      S_DRN_POP: begin
        if (!alu_neg) begin
          if (q_live[q_head]) begin
            if (out_free) begin
              credit_next           = alu_res[CRED_W-1:0];
              qctl.pop              = 1'b1;
              out_load              = 1'b1;
              out_word.admitted_id  = q_rd_data;
              out_word.credit_us    = alu_res[CRED_W-1:0];
              out_word.queued_count = q_count - QCNT_W'(1);
            end
          end else begin
            // cancelled entry leaves at no cost
            qctl.pop = 1'b1;
          end
        end
      end
      S_ARM_ISSUE: begin
        if (!(timer_armed || paused || q_count == '0)) begin
          alu_req = '{valid: 1'b1, op: ALU_SUB, a: ALU_W'(cost), b: ALU_W'(credit)};
        end
      end
      S_ARM_CHK: begin
        if (!(alu_neg || alu_res == '0)) begin
          alu_req = '{valid: 1'b1, op: ALU_ADD, a: alu_res, b: ALU_W'(ROUND_UP)};
        end
      end
      S_RND: begin
        // rounded-up deficit over 1000 by reciprocal multiply
        quo_next = ms_prod[RECIP_SHIFT +: QUO_W];
      end
      S_MS: begin
        // quotient stays far below the 16-bit wait_ms range for a 20-bit cost
        wait_next        = (quo < QUO_W'(MIN_WAIT_MS)) ? MS_W'(MIN_WAIT_MS) : MS_W'(quo);
        timer_armed_next = 1'b1;
      end
      S_CAN_RD: begin
        if (idx != q_count) begin
          qctl.rd_en    = 1'b1;
          qctl.rd_addr  = scan_addr;
          can_addr_next = scan_addr;
        end
      end
      S_CAN_CMP: begin
        if (q_live[can_addr] && q_rd_data == id_r) begin
          qctl.kill      = 1'b1;
          qctl.kill_addr = can_addr;
        end
        idx_next = idx + QCNT_W'(1);
      end
      S_STATUS: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_kind              = KIND_STATUS;
          out_last              = 1'b1;
          out_word.admitted_id  = (mode_r == MODE_SUBMIT || mode_r == MODE_CANCEL) ? id_r : '0;
          out_word.status       = status_r;
          out_word.arm_timer    = (wait_r != '0);
          out_word.wait_ms      = wait_r;
          out_word.timer_cancel = tcancel;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cost        <= COST_RESET;
      cap         <= CAP_RESET;
      credit      <= CAP_RESET;
      paused      <= 1'b0;
      timer_armed <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      cost        <= cost_next;
      cap         <= cap_next;
      credit      <= credit_next;
      paused      <= paused_next;
      timer_armed <= timer_armed_next;
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_next;
    id_r      <= id_next;
    elapsed_r <= elapsed_next;
    acc       <= acc_next;
    quo       <= quo_next;
    idx       <= idx_next;
    can_addr  <= can_addr_next;
    status_r  <= status_next;
    wait_r    <= wait_next;
    tcancel   <= tcancel_next;
    if (out_load) begin
      m_tdata <= out_word;
      m_tuser <= out_kind;
      m_tlast <= out_last;
    end
  end

  a_credit_capped: assert property (@(posedge clk) disable iff (rst)
    credit <= cap)
    else $error("credit above cap");

  a_armed_not_paused: assert property (@(posedge clk) disable iff (rst)
    timer_armed |-> !paused)
    else $error("timer armed while paused");

  a_ms_after_rnd: assert property (@(posedge clk) disable iff (rst)
    (state == S_MS) |-> $past(state == S_RND))
    else $error("wait step out of sequence");

endmodule
